// ===== hw/rtl/unsigned_alu_add_sub_mul_div_fact_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the unsigned ALU
// Property wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef UNSIGNED_ALU_ADD_SUB_MUL_DIV_FACT_ASSERT_SVH
`define UNSIGNED_ALU_ADD_SUB_MUL_DIV_FACT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on the rising clock, off during reset.
`define UALU_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ALU assertion failed");
// Next-cycle implication, sampled on the rising clock, off during reset.
`define UALU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ALU assertion failed");
`else
`define UALU_ASSERT_IMPL(label, ante, cons)
`define UALU_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== hw/rtl/ualu_pkg.sv =====
// ----------------------------------------------------------------------------
// Unsigned ALU package
// Field widths, opcodes, status codes and control types shared by the ALU.
// ----------------------------------------------------------------------------
package ualu_pkg;

  // Fixed field widths of the stream items.
  localparam int unsigned FIELD_W   = 48;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned S_TDATA_W = 104;
  localparam int unsigned M_TDATA_W = 104;

  // Default datapath width.
  localparam int unsigned WIDTH_DEF = 48;

  // The factorial product is zero modulo 2^W before k passes W plus this.
  localparam int unsigned FACT_MARGIN = 8;

  // Operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_FACT = 3'd4
  } op_e;

  // Status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_NEG  = 2'd1,
    ST_DIV0 = 2'd2
  } status_e;

  // Modes of the serial multiply/divide unit.
  typedef enum logic {
    U_MUL = 1'b0,
    U_DIV = 1'b1
  } umode_e;

  // Top-level sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_UNIT,
    S_FCHK,
    S_FWAIT,
    S_DONE
  } state_e;

  // Request to the serial unit.
  typedef struct packed {
    logic   start;
    umode_e mode;
  } unit_req_t;

endpackage

// ===== hw/rtl/ualu_serial.sv =====
// ----------------------------------------------------------------------------
// Serial multiply/divide unit
// Shift-add multiply modulo 2^W and restoring divide, one bit per cycle.
// ----------------------------------------------------------------------------
module ualu_serial #(
  parameter int unsigned W = ualu_pkg::WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ualu_pkg::unit_req_t req_i,
  input  logic [W-1:0]        x_i,
  input  logic [W-1:0]        y_i,
  output logic                done_o,
  output logic [W-1:0]        res_o,
  output logic [W-1:0]        rem_o
);
  import ualu_pkg::*;

  localparam int unsigned CW = $clog2(W);

  logic [W-1:0]  hi_q, hi_d;
  logic [W-1:0]  lo_q, lo_d;
  logic [W-1:0]  opnd_q, opnd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  umode_e        mode_q, mode_d;

  logic [W-1:0]  addend;
  logic [W:0]    trial;
  logic [W+1:0]  diff;
  logic          fits;

  // One iteration: add the shifted multiplicand, or try one divisor subtract.
  always_comb begin
    addend = lo_q[0] ? opnd_q : '0;
    trial  = {hi_q, lo_q[W-1]};
    diff   = {1'b0, trial} - {2'b00, opnd_q};
    fits   = ~diff[W+1];

    hi_d   = hi_q;
    lo_d   = lo_q;
    opnd_d = opnd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    mode_d = mode_q;
    done_d = 1'b0;

    if (req_i.start) begin
      hi_d   = '0;
      mode_d = req_i.mode;
      busy_d = 1'b1;
      cnt_d  = CW'(W - 1);
      if (req_i.mode == U_MUL) begin
        lo_d   = y_i;
        opnd_d = x_i;
      end else begin
        lo_d   = x_i;
        opnd_d = y_i;
      end
    end else if (busy_q) begin
      if (mode_q == U_MUL) begin
        hi_d   = hi_q + addend;
        lo_d   = lo_q >> 1;
        opnd_d = opnd_q << 1;
      end else begin
        hi_d   = fits ? diff[W-1:0] : trial[W-1:0];
        lo_d   = {lo_q[W-2:0], fits};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      mode_q <= U_MUL;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
    end
  end

  // Shift registers of the datapath.
  always_ff @(posedge clk_i) begin
    hi_q   <= hi_d;
    lo_q   <= lo_d;
    opnd_q <= opnd_d;
  end

  assign done_o = done_q;
  assign res_o  = (mode_q == U_MUL) ? hi_q : lo_q;
  assign rem_o  = hi_q;

endmodule

// ===== hw/rtl/unsigned_alu_add_sub_mul_div_fact.sv =====
// Add, subtract and unused opcodes are computed in S_CALC and loaded into the output register from S_DONE;
// multiply and divide go through the serial unit, one bit per cycle, between S_CALC and S_DONE.
// Factorial runs up to about WIDTH + 3 multiplies in the serial unit.
// One item is in work at a time; the serial unit sets the rate. A finished result waits in
// the output register while the next item is accepted and computed.
// Reset clears the sequencer and valid flags at once; there is no clearing pass.
// ----------------------------------------------------------------------------
// Unsigned integer ALU
// Add, subtract, multiply, divide with remainder and factorial on a stream.
// ----------------------------------------------------------------------------
`include "unsigned_alu_add_sub_mul_div_fact_assert.svh"

module unsigned_alu_add_sub_mul_div_fact #(
  parameter int unsigned WIDTH = ualu_pkg::WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // op [2:0], operand_a [50:3], operand_b [98:51], zero fill above
  input  logic [ualu_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // value [47:0], remainder [95:48], status [97:96], zero fill above
  output logic [ualu_pkg::M_TDATA_W-1:0] m_axis_tdata_o
);
  import ualu_pkg::*;

  localparam int unsigned KW    = $clog2(WIDTH + FACT_MARGIN + 1);
  localparam int unsigned PAD_W = M_TDATA_W - 2 * FIELD_W - STAT_W;

  state_e      state_q, state_d;
  op_e         op_q;
  logic [WIDTH-1:0] a_q, b_q;
  logic [WIDTH-1:0] res_val_q, res_val_d;
  logic [WIDTH-1:0] res_rem_q, res_rem_d;
  status_e          res_st_q, res_st_d;
  logic [KW-1:0]    k_q, k_d;

  logic             out_valid_q, out_valid_d;
  logic [FIELD_W-1:0] out_val_q, out_rem_q;
  status_e          out_st_q;

  logic             in_acc;
  logic             out_load;
  logic [WIDTH:0]   sub_diff;
  logic             k_past_n;
  logic             prod_zero;

  unit_req_t        unit_req;
  logic [WIDTH-1:0] unit_x, unit_y;
  logic             unit_done;
  logic [WIDTH-1:0] unit_res, unit_rem;

  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load  = (state_q == S_DONE) && (!out_valid_q || m_axis_tready_i);
  assign sub_diff  = {1'b0, a_q} - {1'b0, b_q};
  assign k_past_n  = ((a_q >> KW) == '0) && (a_q[KW-1:0] < k_q);
  assign prod_zero = (res_val_q == '0);

  // Serial multiply/divide unit shared by multiply, divide and factorial.
  ualu_serial #(
    .W(WIDTH)
  ) u_serial (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (unit_req),
    .x_i    (unit_x),
    .y_i    (unit_y),
    .done_o (unit_done),
    .res_o  (unit_res),
    .rem_o  (unit_rem)
  );

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_CALC;
      end
      S_CALC: begin
        case (op_q)
          OP_MUL:  state_d = S_UNIT;
          OP_DIV:  state_d = (b_q == '0) ? S_DONE : S_UNIT;
          OP_FACT: state_d = S_FCHK;
          default: state_d = S_DONE;
        endcase
      end
      S_UNIT: begin
        if (unit_done) state_d = S_DONE;
      end
      S_FCHK: begin
        state_d = (k_past_n || prod_zero) ? S_DONE : S_FWAIT;
      end
      S_FWAIT: begin
        if (unit_done) state_d = S_FCHK;
      end
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and serial unit requests.
  always_comb begin
    s_axis_tready_o = 1'b0;
    unit_req.start  = 1'b0;
    unit_req.mode   = U_MUL;
    unit_x          = a_q;
    unit_y          = b_q;
    case (state_q)
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
      end
      S_CALC: begin
        unit_req.start = (op_q == OP_MUL) || ((op_q == OP_DIV) && (b_q != '0));
        unit_req.mode  = (op_q == OP_DIV) ? U_DIV : U_MUL;
      end
      S_FCHK: begin
        unit_req.start = !(k_past_n || prod_zero);
        unit_x         = res_val_q;
        unit_y         = WIDTH'(k_q);
      end
      default: begin
        s_axis_tready_o = 1'b0;
      end
    endcase
  end

  // Result registers: direct results, serial unit results, factorial product.
  always_comb begin
    res_val_d = res_val_q;
    res_rem_d = res_rem_q;
    res_st_d  = res_st_q;
    k_d       = k_q;
    case (state_q)
      S_CALC: begin
        res_val_d = '0;
        res_rem_d = '0;
        res_st_d  = ST_OK;
        case (op_q)
          OP_ADD: res_val_d = a_q + b_q;
          OP_SUB: begin
            if (sub_diff[WIDTH]) res_st_d = ST_NEG;
            else res_val_d = sub_diff[WIDTH-1:0];
          end
          OP_DIV: begin
            if (b_q == '0) res_st_d = ST_DIV0;
          end
          OP_FACT: begin
            res_val_d = WIDTH'(1);
            k_d       = KW'(2);
          end
          default: res_val_d = '0;
        endcase
      end
      S_UNIT: begin
        if (unit_done) begin
          res_val_d = unit_res;
          res_rem_d = (op_q == OP_DIV) ? unit_rem : '0;
        end
      end
      S_FWAIT: begin
        if (unit_done) begin
          res_val_d = unit_res;
          k_d       = k_q + 1'b1;
        end
      end
      default: k_d = k_q;
    endcase
  end

  // Output slot: free when empty or being taken this cycle.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) out_valid_d = 1'b1;
    else if (m_axis_tready_i) out_valid_d = 1'b0;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Operand, result and output payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q <= op_e'(s_axis_tdata_i[OP_W-1:0]);
      a_q  <= WIDTH'(s_axis_tdata_i[OP_W +: FIELD_W]);
      b_q  <= WIDTH'(s_axis_tdata_i[OP_W + FIELD_W +: FIELD_W]);
    end
    res_val_q <= res_val_d;
    res_rem_q <= res_rem_d;
    res_st_q  <= res_st_d;
    k_q       <= k_d;
    if (out_load) begin
      out_val_q <= FIELD_W'(res_val_q);
      out_rem_q <= FIELD_W'(res_rem_q);
      out_st_q  <= res_st_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{PAD_W{1'b0}}, out_st_q, out_rem_q, out_val_q};

  // Checks on the sequencer and the results.
  `UALU_ASSERT_NEXT(a_accept_to_calc, s_axis_tvalid_i && s_axis_tready_o, state_q == S_CALC)
  `UALU_ASSERT_IMPL(a_done_while_waiting, unit_done, state_q == S_UNIT || state_q == S_FWAIT)
  `UALU_ASSERT_IMPL(a_div0_gives_zero, m_axis_tvalid_o && out_st_q == ST_DIV0, out_val_q == '0 && out_rem_q == '0)
  `UALU_ASSERT_IMPL(a_neg_gives_zero, m_axis_tvalid_o && out_st_q == ST_NEG, out_val_q == '0 && out_rem_q == '0)

endmodule

// ===== dv/alu_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Result checker for the unsigned ALU
// Watches both stream channels, computes the expected result of every
// accepted item and compares each returned result field by field.
// ----------------------------------------------------------------------------
module alu_result_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  input  logic                           s_tready_i,
  // op [2:0], operand_a [50:3], operand_b [98:51], zero fill above
  input  logic [ualu_pkg::S_TDATA_W-1:0] s_tdata_i,
  input  logic                           m_tvalid_i,
  input  logic                           m_tready_i,
  // value [47:0], remainder [95:48], status [97:96], zero fill above
  input  logic [ualu_pkg::M_TDATA_W-1:0] m_tdata_i,
  output int                             fail_count_o,
  output int                             pending_o
);
  import ualu_pkg::*;

  localparam int unsigned REPORT_MAX = 10;

  typedef struct packed {
    logic [FIELD_W-1:0] value;
    logic [FIELD_W-1:0] remainder;
    logic [STAT_W-1:0]  status;
  } alu_result_t;

  alu_result_t pending_results[$];
  int          reported;

  // Running product modulo 2^48; once it hits zero it stays there.
  function automatic logic [FIELD_W-1:0] factorial_wrap(input logic [FIELD_W-1:0] n);
    logic [FIELD_W-1:0] prod;
    logic [FIELD_W-1:0] k;
    prod = 1;
    for (k = 2; k <= n; k++) begin
      prod = prod * k;
      if (prod == '0) break;
    end
    return prod;
  endfunction

  // Expected result of one item.
  function automatic alu_result_t alu_compute(input logic [OP_W-1:0] op,
                                              input logic [FIELD_W-1:0] a,
                                              input logic [FIELD_W-1:0] b);
    alu_result_t r;
    r.value     = '0;
    r.remainder = '0;
    r.status    = ST_OK;
    case (op)
      OP_ADD: r.value = a + b;
      OP_SUB: begin
        if (b > a) r.status = ST_NEG;
        else r.value = a - b;
      end
      OP_MUL: r.value = a * b;
      OP_DIV: begin
        if (b == '0) begin
          r.status = ST_DIV0;
        end else begin
          r.value     = a / b;
          r.remainder = a % b;
        end
      end
      OP_FACT: r.value = factorial_wrap(a);
      default: ;
    endcase
    return r;
  endfunction

  // Compare the returned item first, then record the newly accepted one.
  always @(posedge clk_i) begin
    alu_result_t got;
    alu_result_t want;
    if (!rst_ni) begin
      fail_count_o <= 0;
      pending_o    <= 0;
      reported     = 0;
      pending_results.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got.value     = m_tdata_i[FIELD_W-1:0];
        got.remainder = m_tdata_i[2*FIELD_W-1:FIELD_W];
        got.status    = m_tdata_i[2*FIELD_W+STAT_W-1:2*FIELD_W];
        if (pending_results.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          if (reported < REPORT_MAX) begin
            $display("%0t: result with nothing pending: value %h remainder %h status %0d",
                     $realtime, got.value, got.remainder, got.status);
            reported++;
          end
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            fail_count_o <= fail_count_o + 1;
            if (reported < REPORT_MAX) begin
              $display("%0t: mismatch: expected value %h remainder %h status %0d",
                       $realtime, want.value, want.remainder, want.status);
              $display("%0t:           actual value %h remainder %h status %0d",
                       $realtime, got.value, got.remainder, got.status);
              reported++;
            end
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        pending_results.push_back(alu_compute(s_tdata_i[OP_W-1:0],
                                              s_tdata_i[OP_W+FIELD_W-1:OP_W],
                                              s_tdata_i[OP_W+2*FIELD_W-1:OP_W+FIELD_W]));
      end
      pending_o <= pending_results.size();
    end
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the unsigned ALU
// Drives directed corner items and random items with idle bursts on both
// stream sides, one long output stall, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;
  import ualu_pkg::*;

  localparam int unsigned  ITEM_COUNT   = 230;
  localparam int unsigned  CALM_ITEMS   = 30;
  localparam int unsigned  HOLD_AT_ITEM = 40;
  localparam int unsigned  HOLD_CYCLES  = 400;
  localparam int unsigned  DRAIN_CYCLES = 100;
  localparam int unsigned  CYCLE_LIMIT  = 3_000_000;
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_MID   = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;
  localparam logic [FIELD_W-1:0] ALL_ONES    = '1;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 s_axis_tvalid  = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata   = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready  = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  int  fail_count;
  int  pending;
  int  items_sent = 0;
  int  cycles     = 0;
  bit  calm       = 1'b0;

  unsigned_alu_add_sub_mul_div_fact #(.WIDTH(WIDTH_DEF)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  alu_result_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 12 ns clock.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offer one item and hold it until the ALU takes it.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [FIELD_W-1:0] a,
                           input logic [FIELD_W-1:0] b);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(S_TDATA_W - OP_W - 2*FIELD_W){1'b0}}, b, a, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  // Operand drawn from a mix of corner values and full-range noise.
  function automatic logic [FIELD_W-1:0] pick_operand();
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return ALL_ONES;
      2:       return FIELD_W'($urandom_range(0, 255));
      3:       return FIELD_W'(1) << $urandom_range(0, FIELD_W - 1);
      4:       return ALL_ONES >> $urandom_range(0, FIELD_W - 1);
      default: return wide[FIELD_W-1:0];
    endcase
  endfunction

  // Random item: mostly well-formed operations, a few spare opcodes.
  task automatic send_random_item();
    logic [OP_W-1:0]    op;
    logic [FIELD_W-1:0] a;
    logic [FIELD_W-1:0] b;
    int                 pick;
    pick = $urandom_range(0, 99);
    a    = pick_operand();
    b    = pick_operand();
    if (pick < 22) begin
      op = OP_ADD;
    end else if (pick < 44) begin
      op = OP_SUB;
      // Pull the operands together so equal and off-by-one cases show up.
      if ($urandom_range(0, 3) == 0) b = a;
      else if ($urandom_range(0, 3) == 0) b = a + FIELD_W'($urandom_range(0, 2)) - 1;
    end else if (pick < 64) begin
      op = OP_MUL;
    end else if (pick < 84) begin
      op = OP_DIV;
      if ($urandom_range(0, 2) == 0) b = FIELD_W'($urandom_range(1, 1000));
    end else if (pick < 96) begin
      op = OP_FACT;
      // Keep most factorials short, since a long one ties up the serial unit.
      if ($urandom_range(0, 9) < 7) a = FIELD_W'($urandom_range(0, 60));
    end else begin
      op = OP_SPARE_FIRST + OP_W'($urandom_range(0, 2));
    end
    send_item(op, a, b);
  endtask

  // Output side: random stall bursts, one long hold-off, none near the end.
  initial begin
    bit held;
    held = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (calm) begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end else if (!held && items_sent >= HOLD_AT_ITEM) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(0, 3) != 0);
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners.
    send_item(OP_ADD, '0, '0);
    send_item(OP_ADD, ALL_ONES, ALL_ONES);
    send_item(OP_ADD, ALL_ONES, FIELD_W'(1));
    send_item(OP_SUB, ALL_ONES, '0);
    send_item(OP_SUB, FIELD_W'(12345), FIELD_W'(12345));
    send_item(OP_SUB, FIELD_W'(5), FIELD_W'(6));
    send_item(OP_SUB, '0, ALL_ONES);
    send_item(OP_MUL, ALL_ONES, ALL_ONES);
    send_item(OP_MUL, ALL_ONES, '0);
    send_item(OP_MUL, FIELD_W'(1) << (FIELD_W - 1), FIELD_W'(2));
    send_item(OP_DIV, ALL_ONES, '0);
    send_item(OP_DIV, ALL_ONES, FIELD_W'(1));
    send_item(OP_DIV, ALL_ONES, ALL_ONES);
    send_item(OP_DIV, FIELD_W'(7), ALL_ONES);
    send_item(OP_DIV, ALL_ONES, FIELD_W'(10));
    send_item(OP_FACT, '0, ALL_ONES);
    send_item(OP_FACT, FIELD_W'(1), '0);
    send_item(OP_FACT, FIELD_W'(20), '0);
    send_item(OP_FACT, FIELD_W'(51), '0);
    send_item(OP_FACT, FIELD_W'(52), '0);
    send_item(OP_FACT, ALL_ONES, '0);
    send_item(OP_SPARE_FIRST, ALL_ONES, ALL_ONES);
    send_item(OP_SPARE_MID, FIELD_W'(3), FIELD_W'(4));
    send_item(OP_SPARE_LAST, ALL_ONES, '0);

    // Random part with idle bursts, quiet in the closing stretch.
    while (items_sent < ITEM_COUNT) begin
      if (items_sent >= ITEM_COUNT - CALM_ITEMS) calm = 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
      send_random_item();
    end
    s_axis_tvalid <= 1'b0;

    // Let the checker see the last item, then drain.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
